/* rtl/core/nsr_pkg.sv */
`default_nettype none
package nsr_pkg;

  // Fixed-point format and iteration count
  localparam int unsigned DataW       = 32;
  localparam int unsigned FracBits    = 16;
  localparam int unsigned NewtonSteps = 10;

  // Shifted dividend width and counter widths
  localparam int unsigned NumW     = DataW + FracBits;
  localparam int unsigned DivCntW  = $clog2(NumW);
  localparam int unsigned IterW    = $clog2(NewtonSteps + 1);
  localparam int unsigned PcW      = 3;

  // Datapath operation selected by a control word
  typedef enum logic [2:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_DIV_START,
    OP_DIV_WAIT,
    OP_UPDATE,
    OP_EMIT
  } nsr_op_e;

  // Jump condition of a control word; the sequencer falls through when false
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_IN_IDLE,
    COND_NONPOS,
    COND_DIV_BUSY,
    COND_ITER_MORE,
    COND_OUT_BLOCKED
  } nsr_cond_e;

  typedef struct packed {
    nsr_op_e        op;
    nsr_cond_e      cond;
    logic [PcW-1:0] target;
  } nsr_uword_t;

  // Status flags from the datapath that the sequencer branches on
  typedef struct packed {
    logic in_idle;
    logic nonpos;
    logic div_busy;
    logic iter_more;
    logic out_blocked;
  } nsr_flags_t;

  // Step addresses
  localparam logic [PcW-1:0] PC_ACCEPT = 3'd0;
  localparam logic [PcW-1:0] PC_CHECK  = 3'd1;
  localparam logic [PcW-1:0] PC_START  = 3'd2;
  localparam logic [PcW-1:0] PC_WAIT   = 3'd3;
  localparam logic [PcW-1:0] PC_UPDATE = 3'd4;
  localparam logic [PcW-1:0] PC_EMIT   = 3'd5;
  localparam logic [PcW-1:0] PC_WRAP   = 3'd6;

  // Control program
  function automatic nsr_uword_t ucode_rom(input logic [PcW-1:0] pc);
    nsr_uword_t w;
    case (pc)
      PC_ACCEPT: w = '{op: OP_ACCEPT,    cond: COND_IN_IDLE,     target: PC_ACCEPT};
      PC_CHECK:  w = '{op: OP_NOP,       cond: COND_NONPOS,      target: PC_EMIT};
      PC_START:  w = '{op: OP_DIV_START, cond: COND_NEVER,       target: PC_ACCEPT};
      PC_WAIT:   w = '{op: OP_DIV_WAIT,  cond: COND_DIV_BUSY,    target: PC_WAIT};
      PC_UPDATE: w = '{op: OP_UPDATE,    cond: COND_ITER_MORE,   target: PC_START};
      PC_EMIT:   w = '{op: OP_EMIT,      cond: COND_OUT_BLOCKED, target: PC_EMIT};
      PC_WRAP:   w = '{op: OP_NOP,       cond: COND_ALWAYS,      target: PC_ACCEPT};
      default:   w = '{op: OP_NOP,       cond: COND_ALWAYS,      target: PC_ACCEPT};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/nsr_divider.sv */
`default_nettype none
module nsr_divider (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [nsr_pkg::NumW-1:0]  dividend_i,
  input  wire logic [nsr_pkg::DataW-1:0] divisor_i,
  output logic                           busy_o,
  output logic [nsr_pkg::DataW-1:0]      quotient_o
);
  import nsr_pkg::*;

  localparam logic [DivCntW-1:0] LastCnt = DivCntW'(NumW - 1);

  logic               busy_q, busy_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0]    work_q, work_d;
  logic [DataW-1:0]   rem_q, rem_d;
  logic [DataW-1:0]   div_q, div_d;
  logic [DataW:0]     rem_sh;
  logic               ge;
  logic               sat;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh = {rem_q, work_q[NumW-1]};
    ge     = rem_sh >= {1'b0, div_q};
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    work_d = work_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = LastCnt;
      work_d = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = ge ? DataW'(rem_sh - {1'b0, div_q}) : rem_sh[DataW-1:0];
      work_d = {work_q[NumW-2:0], ge};
      cnt_d  = cnt_q - DivCntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  // Quotient saturates to the data width
  assign sat        = |(work_q >> DataW);
  assign quotient_o = sat ? '1 : work_q[DataW-1:0];
  assign busy_o     = busy_q;

endmodule
`default_nettype wire

/* rtl/core/nsr_sequencer.sv */
`default_nettype none
module nsr_sequencer (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire nsr_pkg::nsr_flags_t flags_i,
  output nsr_pkg::nsr_op_e         op_o
);
  import nsr_pkg::*;

  logic [PcW-1:0] pc_q, pc_d;
  nsr_uword_t     uword;
  logic           take;

  assign uword = ucode_rom(pc_q);

  // Branch condition select
  always_comb begin
    case (uword.cond)
      COND_NEVER:       take = 1'b0;
      COND_ALWAYS:      take = 1'b1;
      COND_IN_IDLE:     take = flags_i.in_idle;
      COND_NONPOS:      take = flags_i.nonpos;
      COND_DIV_BUSY:    take = flags_i.div_busy;
      COND_ITER_MORE:   take = flags_i.iter_more;
      COND_OUT_BLOCKED: take = flags_i.out_blocked;
      default:          take = 1'b1;
    endcase
    pc_d = take ? uword.target : pc_q + PcW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_ACCEPT;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign op_o = uword.op;

endmodule
`default_nettype wire

/* rtl/core/newton_square_root_core.sv */
// Newton-Raphson square root, unsigned Q16.16 result from a signed Q16.16 operand.
//
// Input channel: in_valid_i / in_stall_o with value_i. A beat is taken when
// in_valid_i is high and in_stall_o is low. Output channel: out_valid_o /
// out_stall_i with root_o and nonpositive_o; one result beat per input beat.
//
// Zero or negative operands skip the iteration. Positive operands run 10
// Newton steps, each one 48-bit by 32-bit restoring division at one quotient
// bit per cycle (a step: start, divide, see the divider done, update). One
// operand is in work at a time; the next input beat is taken only after the
// result of the last one has gone into the output register. For positive
// operands the pace is set by the serial divider.
//
// The result sits in an output register, so the next operand is taken while a
// result waits. If the receiver stalls and a second result is ready, the
// control program holds until the output register frees up.
// Reset clears the program counter, the output valid flag and the divider busy flag; no item is in flight.
`default_nettype none
module newton_square_root_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic signed [31:0]        value_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [nsr_pkg::DataW-1:0]      root_o,
  output logic                           nonpositive_o
);
  import nsr_pkg::*;

  nsr_op_e          op;
  nsr_flags_t       flags;
  logic             in_beat;
  logic             out_blocked;
  logic             emit_load;
  logic             div_busy;
  logic [DataW-1:0] quotient;

  logic [DataW-1:0] value_q, value_d;
  logic [DataW-1:0] guess_q, guess_d;
  logic             nonpos_q, nonpos_d;
  logic [IterW-1:0] iter_q, iter_d;
  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] root_q, root_d;
  logic             out_nonpos_q, out_nonpos_d;

  logic [DataW-1:0] half_val;
  logic [DataW:0]   sum;
  logic [DataW-1:0] half_sum;

  // Handshake
  assign in_stall_o  = (op != OP_ACCEPT);
  assign in_beat     = in_valid_i && !in_stall_o;
  assign out_blocked = out_valid_q && out_stall_i;
  assign emit_load   = (op == OP_EMIT) && !out_blocked;

  assign flags = '{
    in_idle:     !in_valid_i,
    nonpos:      nonpos_q,
    div_busy:    div_busy,
    iter_more:   (iter_q != IterW'(1)),
    out_blocked: out_blocked
  };

  nsr_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .op_o    (op)
  );

  nsr_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (op == OP_DIV_START),
    .dividend_i (NumW'(value_q) << FracBits),
    .divisor_i  (guess_q),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  // Start guess and Newton update, each floored at one LSB
  assign half_val = DataW'(value_i) >> 1;
  assign sum      = {1'b0, guess_q} + {1'b0, quotient};
  assign half_sum = sum[DataW:1];

  always_comb begin
    value_d  = value_q;
    guess_d  = guess_q;
    nonpos_d = nonpos_q;
    iter_d   = iter_q;
    case (op)
      OP_ACCEPT: begin
        if (in_beat) begin
          value_d  = DataW'(value_i);
          guess_d  = (half_val == '0) ? DataW'(1) : half_val;
          nonpos_d = value_i[31] || (value_i == '0);
          iter_d   = IterW'(NewtonSteps);
        end
      end
      OP_UPDATE: begin
        guess_d = (half_sum == '0) ? DataW'(1) : half_sum;
        iter_d  = iter_q - IterW'(1);
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d  = out_valid_q && out_stall_i;
    root_d       = root_q;
    out_nonpos_d = out_nonpos_q;
    if (emit_load) begin
      out_valid_d  = 1'b1;
      root_d       = nonpos_q ? '0 : guess_q;
      out_nonpos_d = nonpos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      nonpos_q    <= 1'b0;
      iter_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      nonpos_q    <= nonpos_d;
      iter_q      <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q      <= value_d;
    guess_q      <= guess_d;
    root_q       <= root_d;
    out_nonpos_q <= out_nonpos_d;
  end

  assign out_valid_o   = out_valid_q;
  assign root_o        = root_q;
  assign nonpositive_o = out_nonpos_q;

  // Checks
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == OP_DIV_START) |-> !div_busy)
    else $error("divider started while busy");

  a_nonpos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && nonpositive_o) |-> (root_o == '0))
    else $error("nonpositive result with nonzero root");

  a_pos_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !nonpositive_o) |-> (root_o != '0))
    else $error("positive operand gave zero root");

  a_iter_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> (iter_q == IterW'(NewtonSteps)))
    else $error("step counter not loaded on input beat");

endmodule
`default_nettype wire
